// ===== hw/rtl/bed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_pkg
// Shared sizes, register defaults and pipeline types of the binary edge
// detector.
// ----------------------------------------------------------------------------
package bed_pkg;

    // frame geometry
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 256;

    // column index, input row index (runs two rows past the frame while
    // the tail is flushed) and output row index
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT + 2);
    localparam int OROW_W = $clog2(HEIGHT);

    localparam int SAMPLE_W = 8;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 8'd127;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 3);

    // frame border flags of the pixel being released
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_border;

    // item in flight between the line store read and the window update
    typedef struct packed {
        logic             emit;
        logic             px_bit;
        logic [COL_W-1:0] col;
        t_border          brd;
    } t_stage;

endpackage

// ===== hw/rtl/bed_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bed_in_if / bed_out_if
// Valid/ready channels of the binary edge detector: sample requests in,
// result pixels out.
// ----------------------------------------------------------------------------
interface bed_in_if;
    logic                             valid;
    logic                             ready;
    logic [bed_pkg::SAMPLE_W-1:0]     green_sample;
    logic                             drain;

    modport source (output valid, output green_sample, output drain, input ready);
    modport sink   (input valid, input green_sample, input drain, output ready);
endinterface

interface bed_out_if;
    logic valid;
    logic ready;
    logic white;
    logic frame_last;

    modport source (output valid, output white, output frame_last, input ready);
    modport sink   (input valid, input white, input frame_last, output ready);
endinterface

// ===== hw/rtl/binary_edge_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_edge_detect
// Thresholded 3x3 edge detector over one fixed-size frame in raster order.
// ----------------------------------------------------------------------------
// usage
//  - i_in carries one request per pixel: green_sample and drain. a pixel is
//    binarized (sample > threshold is white) and enters a 2-bit wide line
//    store that holds the two rows above it, plus a 3x3 window register
//  - a black pixel with any white in-frame 8-neighbor comes out as 0 (edge),
//    every other pixel as 1. frame_last marks the final pixel of the frame
//  - pixel (r,c) is released by the request of pixel (r+1,c+1); after the
//    frame WIDTH+1 drain requests flush the rest. drain before the frame is
//    complete is dropped, a pixel after it counts as a drain
//  - throughput: one request per cycle while i_in.ready is high, set by
//    the single read and single write port of the line store (read at
//    accept, written back from the store read stage)
//  - a released result passes the store read and window registers, then waits in a 4-entry queue ahead of o_out
//  - when o_out stalls the queue fills; i_in.ready drops once queue plus
//    results in flight reach its depth, so nothing is lost
//  - reset (i_rst_n low, synchronous) clears counters, window, queue and
//    sets threshold to 127; line store contents need no clearing
//  - i_cfg_wr_en/i_cfg_wr_data write the threshold while the block is idle
// ----------------------------------------------------------------------------
module binary_edge_detect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [bed_pkg::SAMPLE_W-1:0]  i_cfg_wr_data,
    bed_in_if.sink                        i_in,
    bed_out_if.source                     o_out
);

    // configuration
    logic [bed_pkg::SAMPLE_W-1:0] r_threshold;

    // raster position of the next request and of the next pixel released
    logic [bed_pkg::COL_W-1:0]  r_in_col,  n_in_col;
    logic [bed_pkg::ROW_W-1:0]  r_in_row,  n_in_row;
    logic [bed_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [bed_pkg::OROW_W-1:0] r_out_row, n_out_row;

    // line store: bit 1 = row above, bit 0 = two rows above
    logic [1:0] r_row_store [bed_pkg::WIDTH];
    logic [1:0] r_ram_q;

    // stage 1 (store read pending) and stage 2 (window ready)
    logic                   r_s1_vld;
    bed_pkg::t_stage        r_s1;
    logic                   r_s2_vld;
    bed_pkg::t_border       r_s2_brd;

    // 3x3 window: [8:6] left column, [5:3] center, [2:0] right; top bit high
    logic [8:0] r_win;

    // result queue
    logic                       r_fifo_white [bed_pkg::FIFO_DEPTH];
    logic                       r_fifo_last  [bed_pkg::FIFO_DEPTH];
    logic [bed_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [bed_pkg::CNT_W-1:0]  r_fifo_cnt;

    logic w_accept, w_done, w_adv, w_emit, w_is_last, w_px_bit;
    logic w_push, w_pop, w_any_white, w_white;
    logic [bed_pkg::CNT_W-1:0] w_pend;
    bed_pkg::t_border w_brd;

    // ---------------------------------------------------------------- accept
    assign w_accept = i_in.valid && i_in.ready;
    // every frame pixel has arrived: requests now only flush
    assign w_done   = r_in_row >= bed_pkg::ROW_W'(bed_pkg::HEIGHT);
    assign w_adv    = w_accept && (!i_in.drain || w_done);
    // request releases a pixel once one row plus one pixel is buffered
    assign w_emit   = w_done || (r_in_row >= bed_pkg::ROW_W'(2)) ||
                      ((r_in_row == bed_pkg::ROW_W'(1)) && (r_in_col != '0));
    assign w_is_last = (r_out_row == bed_pkg::OROW_W'(bed_pkg::HEIGHT - 1)) &&
                       (r_out_col == bed_pkg::COL_W'(bed_pkg::WIDTH - 1));
    assign w_px_bit = !i_in.drain && !w_done && (i_in.green_sample > r_threshold);

    always_comb begin
        w_brd.top_ok   = r_out_row != '0;
        w_brd.bot_ok   = r_out_row != bed_pkg::OROW_W'(bed_pkg::HEIGHT - 1);
        w_brd.left_ok  = r_out_col != '0;
        w_brd.right_ok = r_out_col != bed_pkg::COL_W'(bed_pkg::WIDTH - 1);
        w_brd.last     = w_is_last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_adv) begin
            if (w_emit && w_is_last) begin
                // frame wrap
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (r_in_col == bed_pkg::COL_W'(bed_pkg::WIDTH - 1)) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (w_emit) begin
                    if (r_out_col == bed_pkg::COL_W'(bed_pkg::WIDTH - 1)) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bed_pkg::THRESH_RESET;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_win       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_s1_vld  <= w_adv;
            r_s2_vld  <= r_s1_vld && r_s1.emit;
            if (r_s1_vld) begin
                // shift in the column {two above, above, new}
                r_win <= {r_win[5:0], r_ram_q[0], r_ram_q[1], r_s1.px_bit};
            end
        end
    end

    // stage payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.emit   <= w_emit;
            r_s1.px_bit <= w_px_bit;
            r_s1.col    <= r_in_col;
            r_s1.brd    <= w_brd;
        end
        if (r_s1_vld) begin
            r_s2_brd <= r_s1.brd;
        end
    end

    // ------------------------------------------------------------ line store
    // read at accept, write back the shifted column in the next cycle; the
    // same entry comes back only a full row later
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ram_q <= r_row_store[r_in_col];
        end
        if (r_s1_vld) begin
            r_row_store[r_s1.col] <= {r_s1.px_bit, r_ram_q[1]};
        end
    end

    // ---------------------------------------------------------------- result
    // neighbors outside the frame count as black
    assign w_any_white =
        (r_win[8] && r_s2_brd.top_ok && r_s2_brd.left_ok)  ||
        (r_win[7] && r_s2_brd.left_ok)                     ||
        (r_win[6] && r_s2_brd.bot_ok && r_s2_brd.left_ok)  ||
        (r_win[5] && r_s2_brd.top_ok)                      ||
        (r_win[3] && r_s2_brd.bot_ok)                      ||
        (r_win[2] && r_s2_brd.top_ok && r_s2_brd.right_ok) ||
        (r_win[1] && r_s2_brd.right_ok)                    ||
        (r_win[0] && r_s2_brd.bot_ok && r_s2_brd.right_ok);
    assign w_white = r_win[4] || !w_any_white;

    // ----------------------------------------------------------------- queue
    assign w_push = r_s2_vld;
    assign w_pop  = o_out.valid && o_out.ready;
    // reserve room for every result still in the pipe
    assign w_pend = r_fifo_cnt + bed_pkg::CNT_W'(r_s1_vld && r_s1.emit)
                  + bed_pkg::CNT_W'(r_s2_vld);
    assign i_in.ready = w_pend < bed_pkg::CNT_W'(bed_pkg::FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == bed_pkg::FIFO_AW'(bed_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == bed_pkg::FIFO_AW'(bed_pkg::FIFO_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo_white[r_wr_ptr] <= w_white;
            r_fifo_last[r_wr_ptr]  <= r_s2_brd.last;
        end
    end

    assign o_out.valid      = r_fifo_cnt != '0;
    assign o_out.white      = r_fifo_white[r_rd_ptr];
    assign o_out.frame_last = r_fifo_last[r_rd_ptr];

    // ------------------------------------------------------------ assertions
    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= bed_pkg::CNT_W'(bed_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_fifo_cnt < bed_pkg::CNT_W'(bed_pkg::FIFO_DEPTH)) || w_pop)
        else $error("push into full result queue");

    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_is_last) |=> (r_in_row == '0) && (r_in_col == '0))
        else $error("counters not cleared after last pixel");

    a_in_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= bed_pkg::ROW_W'(bed_pkg::HEIGHT + 1))
        else $error("input row past flush range");

    a_s2_follows_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> $past(r_s1_vld))
        else $error("window stage without store read");

endmodule
